/* rtl/point_mass_euler_step_with_walls_defines.svh */
// Assertion macros for the point mass integrator checker.
`ifndef POINT_MASS_EULER_STEP_WITH_WALLS_DEFINES_SVH
`define POINT_MASS_EULER_STEP_WITH_WALLS_DEFINES_SVH

// Property that must hold in the cycle after the trigger, outside reset.
`define PMES_ASSERT_NEXT(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("pmes: next-cycle check failed");

// Property that must hold in the cycle after the trigger, reset included.
`define PMES_ASSERT_NEXT_ALWAYS(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) (trig) |=> (cons)) \
      else $error("pmes: reset check failed");

`endif

/* rtl/pmes_pkg.sv */
`default_nettype none

package pmes_pkg;

   // Word format
   localparam int WORD_BITS      = 32;
   localparam int FRAC_BITS      = 16;
   localparam int DT_BITS        = 16;
   localparam int GEOM_BITS      = 31;
   localparam int KIND_BITS      = 2;
   localparam int HIT_BITS       = 3;
   localparam int MUL_BITS       = WORD_BITS + 1;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int LIM_BITS       = WORD_BITS + 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = WORD_BITS;
   localparam int UPC_BITS       = 5;

   // Saturation bounds, extended to the product width
   localparam logic signed [PROD_BITS-1:0] SAT_HI =
      {{(PROD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [PROD_BITS-1:0] SAT_LO =
      {{(PROD_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

   // Register reset values
   localparam logic [WORD_BITS-1:0]        INV_MASS_RESET    = 32'd65536;
   localparam logic [GEOM_BITS-1:0]        RADIUS_RESET      = 31'd655360;
   localparam logic signed [WORD_BITS-1:0] GRAVITY_RESET     = 32'sd642908;
   localparam logic [GEOM_BITS-1:0]        AREA_WIDTH_RESET  = 31'd52428800;
   localparam logic [GEOM_BITS-1:0]        AREA_HEIGHT_RESET = 31'd39321600;
   localparam logic signed [WORD_BITS-1:0] START_X_RESET     = 32'sd0;
   localparam logic signed [WORD_BITS-1:0] START_Y_RESET     = 32'sd0;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD_FORCE   = 2'd0,
      KIND_STEP        = 2'd1,
      KIND_CLEAR_FORCE = 2'd2,
      KIND_UNUSED      = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INV_MASS    = 3'd0,
      CSR_RADIUS      = 3'd1,
      CSR_GRAVITY     = 3'd2,
      CSR_AREA_WIDTH  = 3'd3,
      CSR_AREA_HEIGHT = 3'd4,
      CSR_START_X     = 3'd5,
      CSR_START_Y     = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      REG_POS_X = 3'd0,
      REG_POS_Y = 3'd1,
      REG_VEL_X = 3'd2,
      REG_VEL_Y = 3'd3,
      REG_ACC_X = 3'd4,
      REG_ACC_Y = 3'd5
   } reg_sel_type;

   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_DT   = 2'd1,
      MUL_INV  = 2'd2
   } mul_op_type;

   typedef enum logic [2:0] {
      ALU_NOP     = 3'd0,
      ALU_ADD     = 3'd1,
      ALU_ZERO    = 3'd2,
      ALU_WALL_HI = 3'd3,
      ALU_WALL_LO = 3'd4
   } alu_op_type;

   typedef enum logic [1:0] {
      SRC_GRAVITY = 2'd0,
      SRC_PUSH_X  = 2'd1,
      SRC_PUSH_Y  = 2'd2,
      SRC_PRODUCT = 2'd3
   } src_sel_type;

   typedef enum logic [1:0] {
      LIM_FLOOR = 2'd0,
      LIM_RIGHT = 2'd1,
      LIM_LEFT  = 2'd2
   } lim_sel_type;

   typedef logic [UPC_BITS-1:0] upc_type;

   // Microprogram addresses
   localparam upc_type UA_TEST_ADD   = 5'd0;
   localparam upc_type UA_TEST_STEP  = 5'd1;
   localparam upc_type UA_TEST_CLEAR = 5'd2;
   localparam upc_type UA_END_NONE   = 5'd3;
   localparam upc_type UA_ADD_X      = 5'd4;
   localparam upc_type UA_ADD_Y      = 5'd5;
   localparam upc_type UA_END_ADD    = 5'd6;
   localparam upc_type UA_CLR_X      = 5'd7;
   localparam upc_type UA_CLR_Y      = 5'd8;
   localparam upc_type UA_END_CLR    = 5'd9;
   localparam upc_type UA_GRAVITY    = 5'd10;
   localparam upc_type UA_INV_X      = 5'd11;
   localparam upc_type UA_VEL_X      = 5'd12;
   localparam upc_type UA_INV_Y      = 5'd13;
   localparam upc_type UA_VEL_Y      = 5'd14;
   localparam upc_type UA_POS_X      = 5'd15;
   localparam upc_type UA_POS_Y      = 5'd16;
   localparam upc_type UA_FLOOR      = 5'd17;
   localparam upc_type UA_RIGHT      = 5'd18;
   localparam upc_type UA_LEFT       = 5'd19;
   localparam upc_type UA_END_STEP   = 5'd20;

   typedef struct packed {
      mul_op_type  mul_op;
      reg_sel_type mul_reg;
      alu_op_type  alu_op;
      reg_sel_type alu_reg;
      reg_sel_type aux_reg;
      src_sel_type alu_src;
      lim_sel_type lim_sel;
      logic        jump_en;
      kind_type    jump_kind;
      upc_type     jump_target;
      logic        last;
   } ucode_word_type;

   localparam ucode_word_type UW_NOP = '{
      mul_op:      MUL_NONE,
      mul_reg:     REG_POS_X,
      alu_op:      ALU_NOP,
      alu_reg:     REG_POS_X,
      aux_reg:     REG_POS_X,
      alu_src:     SRC_GRAVITY,
      lim_sel:     LIM_FLOOR,
      jump_en:     1'b0,
      jump_kind:   KIND_ADD_FORCE,
      jump_target: UA_TEST_ADD,
      last:        1'b0
   };

   // Sequencer to datapath
   typedef struct packed {
      logic           start;
      logic           exec;
      logic           out_load;
      ucode_word_type cw;
   } ctrl_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic signed [WORD_BITS-1:0] push_x;
      logic signed [WORD_BITS-1:0] push_y;
      logic [DT_BITS-1:0]     time_step;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] pos_x_out;
      logic signed [WORD_BITS-1:0] pos_y_out;
      logic signed [WORD_BITS-1:0] vel_x_out;
      logic signed [WORD_BITS-1:0] vel_y_out;
      logic [HIT_BITS-1:0]         wall_hits;
      logic                        saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] value;
      logic                        clip;
   } sat_result_type;

   // Clip a wide signed value to the word range
   function automatic sat_result_type sat_word(input logic signed [PROD_BITS-1:0] v);
      sat_result_type r;
      if (v > SAT_HI) begin
         r.value = SAT_HI[WORD_BITS-1:0];
         r.clip  = 1'b1;
      end else if (v < SAT_LO) begin
         r.value = SAT_LO[WORD_BITS-1:0];
         r.clip  = 1'b1;
      end else begin
         r.value = v[WORD_BITS-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   // Status bit reported for each wall
   function automatic logic [HIT_BITS-1:0] hit_mask(input lim_sel_type s);
      logic [HIT_BITS-1:0] m;
      case (s)
         LIM_FLOOR: m = 3'b001;
         LIM_RIGHT: m = 3'b010;
         LIM_LEFT:  m = 3'b100;
         default:   m = 3'b000;
      endcase
      return m;
   endfunction

   // Control store
   function automatic ucode_word_type ucode_rom(input upc_type a);
      ucode_word_type w;
      w = UW_NOP;
      case (a)
         UA_TEST_ADD: begin
            w.jump_en     = 1'b1;
            w.jump_kind   = KIND_ADD_FORCE;
            w.jump_target = UA_ADD_X;
         end
         UA_TEST_STEP: begin
            w.jump_en     = 1'b1;
            w.jump_kind   = KIND_STEP;
            w.jump_target = UA_GRAVITY;
         end
         UA_TEST_CLEAR: begin
            w.jump_en     = 1'b1;
            w.jump_kind   = KIND_CLEAR_FORCE;
            w.jump_target = UA_CLR_X;
         end
         UA_ADD_X: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_ACC_X;
            w.alu_src = SRC_PUSH_X;
         end
         UA_ADD_Y: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_ACC_Y;
            w.alu_src = SRC_PUSH_Y;
         end
         UA_CLR_X: begin
            w.alu_op  = ALU_ZERO;
            w.alu_reg = REG_ACC_X;
         end
         UA_CLR_Y: begin
            w.alu_op  = ALU_ZERO;
            w.alu_reg = REG_ACC_Y;
         end
         UA_GRAVITY: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_ACC_Y;
            w.alu_src = SRC_GRAVITY;
            w.mul_op  = MUL_DT;
            w.mul_reg = REG_ACC_X;
         end
         UA_INV_X: w.mul_op = MUL_INV;
         UA_VEL_X: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_VEL_X;
            w.alu_src = SRC_PRODUCT;
            w.mul_op  = MUL_DT;
            w.mul_reg = REG_ACC_Y;
         end
         UA_INV_Y: w.mul_op = MUL_INV;
         UA_VEL_Y: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_VEL_Y;
            w.alu_src = SRC_PRODUCT;
            w.mul_op  = MUL_DT;
            w.mul_reg = REG_VEL_X;
         end
         UA_POS_X: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_POS_X;
            w.alu_src = SRC_PRODUCT;
            w.mul_op  = MUL_DT;
            w.mul_reg = REG_VEL_Y;
         end
         UA_POS_Y: begin
            w.alu_op  = ALU_ADD;
            w.alu_reg = REG_POS_Y;
            w.alu_src = SRC_PRODUCT;
         end
         UA_FLOOR: begin
            w.alu_op  = ALU_WALL_HI;
            w.alu_reg = REG_POS_Y;
            w.aux_reg = REG_VEL_Y;
            w.lim_sel = LIM_FLOOR;
         end
         UA_RIGHT: begin
            w.alu_op  = ALU_WALL_HI;
            w.alu_reg = REG_POS_X;
            w.aux_reg = REG_VEL_X;
            w.lim_sel = LIM_RIGHT;
         end
         UA_LEFT: begin
            w.alu_op  = ALU_WALL_LO;
            w.alu_reg = REG_POS_X;
            w.aux_reg = REG_VEL_X;
            w.lim_sel = LIM_LEFT;
         end
         UA_END_NONE, UA_END_ADD, UA_END_CLR, UA_END_STEP: w.last = 1'b1;
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/point_mass_euler_step_with_walls.sv */
// Channel | Direction | Handshake          | Beat
// req     | in        | req_valid/req_stall | req_payload (kind, push_x, push_y, time_step)
// rsp     | out       | rsp_valid/rsp_stall | rsp_payload (position, velocity, wall_hits, saturated)
// csr     | in        | csr_we              | csr_index, csr_wdata
//
// Each item runs its own microprogram path: add force, clear force or step; an unused
// kind runs the dispatch words through to a final word. A step runs two dispatch words,
// seven multiply and accumulate words sharing one 33x33 multiplier, three wall words
// and a final word. The block takes no new item until the result of the last is loaded.
// Reset is synchronous and loads the control, configuration and point registers at once;
// there is no clearing pass.
// A stalled result register holds the program on its final word; req_stall is high
// from accept until the result is loaded.
`default_nettype none

module point_mass_euler_step_with_walls import pmes_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_payload_type           req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_payload_type                rsp_payload,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   ctrl_type ctrl;

   // Step counter and control store
   pmes_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_payload.kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // Registers, multiplier and saturating adder
   pmes_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .ctrl        (ctrl),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* rtl/pmes_sequencer.sv */
`default_nettype none

module pmes_sequencer import pmes_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [KIND_BITS-1:0] req_kind,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ctrl_type                  ctrl
);

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   state_type      state_ff, state_in;
   upc_type        upc_ff, upc_in;
   kind_type       kind_ff, kind_in;
   logic           rsp_valid_ff, rsp_valid_in;
   ucode_word_type cw;
   logic           out_free;
   logic           exec;
   logic           out_load;

   // Fetch the current control word
   assign cw       = ucode_rom(upc_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Advance the step counter, take jumps, finish into the result register
   always_comb begin
      state_in     = state_ff;
      upc_in       = upc_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      exec         = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               upc_in   = UA_TEST_ADD;
               kind_in  = kind_type'(req_kind);
            end
         end
         ST_RUN: begin
            if (cw.last) begin
               if (out_free) begin
                  out_load     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               exec = 1'b1;
               if (cw.jump_en && (kind_ff == cw.jump_kind)) begin
                  upc_in = cw.jump_target;
               end else begin
                  upc_in = upc_ff + UPC_BITS'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= UA_TEST_ADD;
         kind_ff      <= KIND_ADD_FORCE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign ctrl.start    = req_valid && (state_ff == ST_IDLE);
   assign ctrl.exec     = exec;
   assign ctrl.out_load = out_load;
   assign ctrl.cw       = cw;

endmodule

`default_nettype wire

/* rtl/pmes_datapath.sv */
`default_nettype none

module pmes_datapath import pmes_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire req_payload_type           req_payload,
   input  wire ctrl_type                  ctrl,
   output rsp_payload_type                rsp_payload
);

   // Configuration
   logic [WORD_BITS-1:0]        inv_mass_ff, inv_mass_in;
   logic [GEOM_BITS-1:0]        radius_ff, radius_in;
   logic signed [WORD_BITS-1:0] gravity_ff, gravity_in;
   logic [GEOM_BITS-1:0]        area_width_ff, area_width_in;
   logic [GEOM_BITS-1:0]        area_height_ff, area_height_in;

   // Point state
   logic signed [WORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic signed [WORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic signed [WORD_BITS-1:0] vel_x_ff, vel_x_in;
   logic signed [WORD_BITS-1:0] vel_y_ff, vel_y_in;
   logic signed [WORD_BITS-1:0] acc_x_ff, acc_x_in;
   logic signed [WORD_BITS-1:0] acc_y_ff, acc_y_in;

   // Item operands and per-item status
   logic signed [WORD_BITS-1:0] push_x_ff, push_x_in;
   logic signed [WORD_BITS-1:0] push_y_ff, push_y_in;
   logic [DT_BITS-1:0]          dt_ff, dt_in;
   logic [HIT_BITS-1:0]         hits_ff, hits_in;
   logic                        sat_ff, sat_in;

   // Shared multiplier
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [PROD_BITS-1:0] prod_shr;
   logic signed [MUL_BITS-1:0]  mul_a, mul_b;

   rsp_payload_type             rsp_payload_ff, rsp_payload_in;

   ucode_word_type              cw;
   logic signed [WORD_BITS-1:0] alu_a, aux_val, mul_val;
   logic signed [PROD_BITS-1:0] src_val, sum_val, aux_ext, neg_val;
   sat_result_type              prod_sat, sum_sat, lim_sat, neg_sat;
   logic                        src_clip;
   logic [WORD_BITS-1:0]        two_r;
   logic signed [LIM_BITS-1:0]  lim, pos_ext;
   logic                        wall_hit;
   logic                        wr_a_en, wr_b_en;
   logic signed [WORD_BITS-1:0] wr_a_val, wr_b_val;
   logic                        clip_now;
   logic [HIT_BITS-1:0]         hit_now;

   assign cw       = ctrl.cw;
   assign prod_shr = prod_ff >>> FRAC_BITS;

   // Select register operands
   always_comb begin
      case (cw.alu_reg)
         REG_POS_X: alu_a = pos_x_ff;
         REG_POS_Y: alu_a = pos_y_ff;
         REG_VEL_X: alu_a = vel_x_ff;
         REG_VEL_Y: alu_a = vel_y_ff;
         REG_ACC_X: alu_a = acc_x_ff;
         REG_ACC_Y: alu_a = acc_y_ff;
         default:   alu_a = '0;
      endcase
      case (cw.aux_reg)
         REG_POS_X: aux_val = pos_x_ff;
         REG_POS_Y: aux_val = pos_y_ff;
         REG_VEL_X: aux_val = vel_x_ff;
         REG_VEL_Y: aux_val = vel_y_ff;
         REG_ACC_X: aux_val = acc_x_ff;
         REG_ACC_Y: aux_val = acc_y_ff;
         default:   aux_val = '0;
      endcase
      case (cw.mul_reg)
         REG_POS_X: mul_val = pos_x_ff;
         REG_POS_Y: mul_val = pos_y_ff;
         REG_VEL_X: mul_val = vel_x_ff;
         REG_VEL_Y: mul_val = vel_y_ff;
         REG_ACC_X: mul_val = acc_x_ff;
         REG_ACC_Y: mul_val = acc_y_ff;
         default:   mul_val = '0;
      endcase
   end

   // Multiplier operands: step length times a register, or scaled force times inv_mass
   always_comb begin
      case (cw.mul_op)
         MUL_DT: begin
            mul_a = {{(MUL_BITS-DT_BITS){1'b0}}, dt_ff};
            mul_b = {mul_val[WORD_BITS-1], mul_val};
         end
         MUL_INV: begin
            mul_a = prod_shr[MUL_BITS-1:0];
            mul_b = {1'b0, inv_mass_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // Saturating accumulate
   always_comb begin
      prod_sat = sat_word(prod_shr);
      src_clip = 1'b0;
      case (cw.alu_src)
         SRC_GRAVITY: src_val = PROD_BITS'(gravity_ff);
         SRC_PUSH_X:  src_val = PROD_BITS'(push_x_ff);
         SRC_PUSH_Y:  src_val = PROD_BITS'(push_y_ff);
         SRC_PRODUCT: begin
            src_val  = PROD_BITS'(prod_sat.value);
            src_clip = prod_sat.clip;
         end
         default:     src_val = '0;
      endcase
      sum_val = PROD_BITS'(alu_a) + src_val;
      sum_sat = sat_word(sum_val);
   end

   // Wall limit, compare, clamp and bounce
   always_comb begin
      two_r = {radius_ff, 1'b0};
      case (cw.lim_sel)
         LIM_FLOOR: lim = LIM_BITS'(area_height_ff) - LIM_BITS'(two_r);
         LIM_RIGHT: lim = LIM_BITS'(area_width_ff) - LIM_BITS'(two_r);
         LIM_LEFT:  lim = LIM_BITS'(two_r);
         default:   lim = '0;
      endcase
      pos_ext = LIM_BITS'(alu_a);
      if (cw.alu_op == ALU_WALL_LO) begin
         wall_hit = pos_ext < lim;
      end else begin
         wall_hit = pos_ext > lim;
      end
      lim_sat = sat_word(PROD_BITS'(lim));
      aux_ext = PROD_BITS'(aux_val);
      neg_val = -aux_ext;
      neg_sat = sat_word(neg_val);
   end

   // Decode the write-back for this step
   always_comb begin
      wr_a_en  = 1'b0;
      wr_b_en  = 1'b0;
      wr_a_val = sum_sat.value;
      wr_b_val = neg_sat.value;
      clip_now = 1'b0;
      hit_now  = '0;
      if (ctrl.exec) begin
         case (cw.alu_op)
            ALU_ADD: begin
               wr_a_en  = 1'b1;
               clip_now = src_clip || sum_sat.clip;
            end
            ALU_ZERO: begin
               wr_a_en  = 1'b1;
               wr_a_val = '0;
            end
            ALU_WALL_HI, ALU_WALL_LO: begin
               if (wall_hit) begin
                  wr_a_en  = 1'b1;
                  wr_b_en  = 1'b1;
                  wr_a_val = lim_sat.value;
                  clip_now = lim_sat.clip || neg_sat.clip;
                  hit_now  = hit_mask(cw.lim_sel);
               end
            end
            default: wr_a_en = 1'b0;
         endcase
      end
   end

   // Next state of the register file and configuration
   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      vel_x_in       = vel_x_ff;
      vel_y_in       = vel_y_ff;
      acc_x_in       = acc_x_ff;
      acc_y_in       = acc_y_ff;
      inv_mass_in    = inv_mass_ff;
      radius_in      = radius_ff;
      gravity_in     = gravity_ff;
      area_width_in  = area_width_ff;
      area_height_in = area_height_ff;
      if (wr_a_en) begin
         case (cw.alu_reg)
            REG_POS_X: pos_x_in = wr_a_val;
            REG_POS_Y: pos_y_in = wr_a_val;
            REG_VEL_X: vel_x_in = wr_a_val;
            REG_VEL_Y: vel_y_in = wr_a_val;
            REG_ACC_X: acc_x_in = wr_a_val;
            REG_ACC_Y: acc_y_in = wr_a_val;
            default:   acc_y_in = acc_y_ff;
         endcase
      end
      if (wr_b_en) begin
         case (cw.aux_reg)
            REG_POS_X: pos_x_in = wr_b_val;
            REG_POS_Y: pos_y_in = wr_b_val;
            REG_VEL_X: vel_x_in = wr_b_val;
            REG_VEL_Y: vel_y_in = wr_b_val;
            REG_ACC_X: acc_x_in = wr_b_val;
            REG_ACC_Y: acc_y_in = wr_b_val;
            default:   acc_y_in = acc_y_ff;
         endcase
      end
      // A start position write also places the point there
      if (csr_we) begin
         case (csr_index)
            CSR_INV_MASS:    inv_mass_in    = csr_wdata;
            CSR_RADIUS:      radius_in      = csr_wdata[GEOM_BITS-1:0];
            CSR_GRAVITY:     gravity_in     = csr_wdata;
            CSR_AREA_WIDTH:  area_width_in  = csr_wdata[GEOM_BITS-1:0];
            CSR_AREA_HEIGHT: area_height_in = csr_wdata[GEOM_BITS-1:0];
            CSR_START_X:     pos_x_in       = csr_wdata;
            CSR_START_Y:     pos_y_in       = csr_wdata;
            default:         inv_mass_in    = inv_mass_ff;
         endcase
      end
   end

   // Latch item operands on accept, gather status through the program
   always_comb begin
      push_x_in = push_x_ff;
      push_y_in = push_y_ff;
      dt_in     = dt_ff;
      if (ctrl.start) begin
         push_x_in = req_payload.push_x;
         push_y_in = req_payload.push_y;
         dt_in     = req_payload.time_step;
         hits_in   = '0;
         sat_in    = 1'b0;
      end else begin
         hits_in   = hits_ff | hit_now;
         sat_in    = sat_ff || clip_now;
      end
   end

   // Result register
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (ctrl.out_load) begin
         rsp_payload_in.pos_x_out = pos_x_ff;
         rsp_payload_in.pos_y_out = pos_y_ff;
         rsp_payload_in.vel_x_out = vel_x_ff;
         rsp_payload_in.vel_y_out = vel_y_ff;
         rsp_payload_in.wall_hits = hits_ff;
         rsp_payload_in.saturated = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff    <= INV_MASS_RESET;
         radius_ff      <= RADIUS_RESET;
         gravity_ff     <= GRAVITY_RESET;
         area_width_ff  <= AREA_WIDTH_RESET;
         area_height_ff <= AREA_HEIGHT_RESET;
         pos_x_ff       <= START_X_RESET;
         pos_y_ff       <= START_Y_RESET;
         vel_x_ff       <= '0;
         vel_y_ff       <= '0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
         hits_ff        <= '0;
         sat_ff         <= 1'b0;
      end else begin
         inv_mass_ff    <= inv_mass_in;
         radius_ff      <= radius_in;
         gravity_ff     <= gravity_in;
         area_width_ff  <= area_width_in;
         area_height_ff <= area_height_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         vel_x_ff       <= vel_x_in;
         vel_y_ff       <= vel_y_in;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
         hits_ff        <= hits_in;
         sat_ff         <= sat_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      push_x_ff      <= push_x_in;
      push_y_ff      <= push_y_in;
      dt_ff          <= dt_in;
      rsp_payload_ff <= rsp_payload_in;
      if (ctrl.exec && (cw.mul_op != MUL_NONE)) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* rtl/pmes_checker.sv */
`default_nettype none

`include "point_mass_euler_step_with_walls_defines.svh"

module pmes_checker import pmes_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire rsp_payload_type           rsp_payload
);

   // Reset leaves the block ready and with no result pending
   `PMES_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, !req_stall && !rsp_valid)

   // An accepted beat makes the block busy
   `PMES_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // No result appears while the block is idle
   `PMES_ASSERT_NEXT(a_no_result_from_idle, !req_stall && !rsp_valid, !rsp_valid)

   // A stalled result stays and holds its payload
   `PMES_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind point_mass_euler_step_with_walls pmes_checker u_checker (.*);

`default_nettype wire
